[hw/rtl/igtm_pkg.sv]
// igtm_pkg: shared constants, types and byte-lane arithmetic for the int8 GEMM tile MAC.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package igtm_pkg;

    localparam int A_ROWS       = 4;    // rows carried by one input beat
    localparam int B_COLS       = 8;    // columns carried by one input beat
    localparam int LANES        = 4;    // k positions per beat
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = LANES * BYTE_W;
    localparam int ACC_W        = 32;
    localparam int IN_W         = (A_ROWS + B_COLS) * WORD_W;
    localparam int OUT_W        = B_COLS * ACC_W;
    localparam int USER_W       = 2;
    localparam int DOT_W        = 19;   // four u8 x s8 products
    localparam int CSUM_W       = 10;   // four s8 values
    localparam int OFFSET_SHIFT = 7;    // x128 offset correction

    typedef logic [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic en;
        logic last;
    } t_pe_ctrl;

    // Dot product of four unsigned A bytes with four signed B bytes.
    function automatic logic signed [DOT_W-1:0] dot4(input logic [WORD_W-1:0] a,
                                                     input logic [WORD_W-1:0] b);
        logic signed [DOT_W-1:0]  acc;
        logic signed [DOT_W-1:0]  av;
        logic signed [DOT_W-1:0]  bv;
        acc = '0;
        for (int p = 0; p < LANES; p++) begin
            av  = DOT_W'($signed({1'b0, a[BYTE_W*p +: BYTE_W]}));
            bv  = DOT_W'($signed(b[BYTE_W*p +: BYTE_W]));
            acc = acc + av * bv;
        end
        return acc;
    endfunction

    // Sum of four signed B bytes.
    function automatic logic signed [CSUM_W-1:0] colsum4(input logic [WORD_W-1:0] b);
        logic signed [CSUM_W-1:0] acc;
        acc = '0;
        for (int p = 0; p < LANES; p++) begin
            acc = acc + CSUM_W'($signed(b[BYTE_W*p +: BYTE_W]));
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/int8_gemm_tile_mac_core.sv]
// int8_gemm_tile_mac_core: top level of the int8 GEMM 4x8 tile MAC.
// Depends on igtm_pkg and igtm_pe.
//
// Usage:
//   Slave stream: one beat per k group of four; tdata carries four A rows and
//   eight B columns, tlast marks the final k group of the tile.
//   Master stream: one beat per tile row, tdata holds the eight column
//   results, tuser the row index, tlast the final row of the tile.
//   Config channel: i_cfg_data sets offset correction (x128 column sum).
//   Throughput: one slave beat per cycle, except while a last beat waits as below. A
//   beat passes an input register and then the accumulator stage; the first row of
//   a tile is valid once its last beat has left the input register, then one row
//   per cycle as the sink takes it. The finished tile sits in a single result
//   buffer, so a tile's last beat waits in the input register until the previous
//   tile's final row leaves.
//   Reset clears the accumulators and column sums and sets correction on.
//   When the sink stalls, the row on the master side holds and the slave
//   side keeps taking beats of the next tile up to its last beat.
`timescale 1ns / 1ps
`default_nettype none

module int8_gemm_tile_mac_core #(
    parameter int TILE_ROWS = 4,
    parameter int TILE_COLS = 8
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // a_row0..a_row3, b_cols01, b_cols23, b_cols45, b_cols67
    input  wire  [igtm_pkg::IN_W-1:0]      s_axis_tdata,
    input  wire                            s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // sum_col0..sum_col7
    output logic [igtm_pkg::OUT_W-1:0]     m_axis_tdata,
    // row_index
    output logic [igtm_pkg::USER_W-1:0]    m_axis_tuser,
    output logic                           m_axis_tlast,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire                            i_cfg_data
);
    import igtm_pkg::*;

    localparam int USED_ROWS = (TILE_ROWS < A_ROWS) ? TILE_ROWS : A_ROWS;
    localparam int USED_COLS = (TILE_COLS < B_COLS) ? TILE_COLS : B_COLS;
    localparam int ROW_W     = (USED_ROWS > 1) ? $clog2(USED_ROWS) : 1;

    logic             r_apply;
    logic             r_in_valid;
    logic [IN_W-1:0]  r_in_data;
    logic             r_in_last;
    logic             r_buf_valid;
    logic [ROW_W-1:0] r_row;
    t_acc             r_csum [USED_COLS];
    t_acc             r_buf  [USED_ROWS][USED_COLS];

    t_acc             w_csum_next [USED_COLS];
    t_acc             w_sum  [USED_ROWS][USED_COLS];
    t_acc             w_corr [USED_ROWS][USED_COLS];
    t_pe_ctrl         w_ctrl;
    logic             w_row_last;
    logic             w_out_done;
    logic             w_buf_free;
    logic             w_go;

    assign o_cfg_ready = 1'b1;

    assign w_row_last  = (r_row == ROW_W'(USED_ROWS - 1));
    assign w_out_done  = r_buf_valid && m_axis_tready && w_row_last;
    assign w_buf_free  = !r_buf_valid || w_out_done;
    assign w_go        = r_in_valid && (!r_in_last || w_buf_free);

    assign s_axis_tready = !r_in_valid || w_go;

    assign w_ctrl = '{en: w_go, last: r_in_last};

    for (genvar c = 0; c < USED_COLS; c++) begin : g_col
        assign w_csum_next[c] = r_csum[c]
                              + ACC_W'(colsum4(r_in_data[A_ROWS*WORD_W + WORD_W*c +: WORD_W]));
        for (genvar r = 0; r < USED_ROWS; r++) begin : g_row
            igtm_pe u_pe (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_a     (r_in_data[WORD_W*r +: WORD_W]),
                .i_b     (r_in_data[A_ROWS*WORD_W + WORD_W*c +: WORD_W]),
                .o_sum   (w_sum[r][c])
            );
            assign w_corr[r][c] = r_apply ? (w_sum[r][c] - (w_csum_next[c] << OFFSET_SHIFT))
                                          : w_sum[r][c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apply <= 1'b1;
        end else if (i_cfg_valid) begin
            r_apply <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < USED_COLS; c++) begin
                r_csum[c] <= '0;
            end
        end else if (w_go) begin
            for (int c = 0; c < USED_COLS; c++) begin
                r_csum[c] <= r_in_last ? '0 : w_csum_next[c];
            end
        end
    end

    // result buffer and row sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
            r_row       <= '0;
        end else if (w_go && r_in_last) begin
            r_buf_valid <= 1'b1;
            r_row       <= '0;
        end else if (w_out_done) begin
            r_buf_valid <= 1'b0;
        end else if (r_buf_valid && m_axis_tready) begin
            r_row <= r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_in_last) begin
            for (int r = 0; r < USED_ROWS; r++) begin
                for (int c = 0; c < USED_COLS; c++) begin
                    r_buf[r][c] <= w_corr[r][c];
                end
            end
        end
    end

    assign m_axis_tvalid = r_buf_valid;
    assign m_axis_tlast  = w_row_last;
    assign m_axis_tuser  = USER_W'(r_row);

    for (genvar c = 0; c < B_COLS; c++) begin : g_out
        if (c < USED_COLS) begin : g_used
            assign m_axis_tdata[ACC_W*c +: ACC_W] = r_buf[r_row][c];
        end else begin : g_zero
            assign m_axis_tdata[ACC_W*c +: ACC_W] = '0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/igtm_pe.sv]
// igtm_pe: one row/column accumulator cell, dot4 per beat into a wrapping 32-bit sum.
// Depends on igtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module igtm_pe (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  igtm_pkg::t_pe_ctrl           i_ctrl,
    input  wire  [igtm_pkg::WORD_W-1:0]        i_a,
    input  wire  [igtm_pkg::WORD_W-1:0]        i_b,
    output igtm_pkg::t_acc                     o_sum
);
    import igtm_pkg::*;

    t_acc r_acc;
    t_acc n_acc;

    // running total including this beat
    assign o_sum = r_acc + ACC_W'(dot4(i_a, i_b));

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.en) begin
            n_acc = i_ctrl.last ? '0 : o_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/igtm_checker.sv]
// igtm_checker: port-level assertions for int8_gemm_tile_mac_core, bound to the top level.
// Depends on igtm_pkg and int8_gemm_tile_mac_core.
`timescale 1ns / 1ps
`default_nettype none

module igtm_checker #(
    parameter int TILE_ROWS = 4
) (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [igtm_pkg::OUT_W-1:0]      m_axis_tdata,
    input wire [igtm_pkg::USER_W-1:0]     m_axis_tuser,
    input wire                            m_axis_tlast
);
    import igtm_pkg::*;

    localparam int USED_ROWS = (TILE_ROWS < A_ROWS) ? TILE_ROWS : A_ROWS;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed under stall");

    // tlast only on the final row
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == USER_W'(USED_ROWS - 1))))
        else $error("tlast does not match final row");

    // rows of a tile follow each other without gaps
    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + USER_W'(1)))
        else $error("row sequence broken");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind int8_gemm_tile_mac_core igtm_checker #(.TILE_ROWS(TILE_ROWS)) u_igtm_checker (.*);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for int8_gemm_tile_mac_core: streams k groups of four with random
// gaps and sink stalls and predicts every tile row in step with the input beats.
// Depends on igtm_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;
    import igtm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 38;
    localparam int SETTLE_CYCLES  = 4;
    localparam bit CORR_OFF       = 1'b0;
    localparam bit CORR_ON        = 1'b1;

    typedef struct packed {
        logic               last_chunk;
        logic [3:0][63:0]   b_pair;     // column 2i in bits 0-31, column 2i+1 in 32-63
        logic [3:0][31:0]   a_row;
    } t_k_group;

    typedef struct packed {
        logic [1:0]         row_index;
        logic [7:0][31:0]   sum_col;
        logic               last_row;
    } t_tile_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;     // a_row0..a_row3, b_cols01..b_cols67
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;          // sum_col0..sum_col7
    logic [USER_W-1:0]  m_axis_tuser;          // row_index
    logic               m_axis_tlast;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data = 1'b0;

    t_k_group           pending[$];
    t_tile_row          rows_due[$];
    logic [31:0]        tile_acc[4][8];
    logic [31:0]        col_sum[8];
    logic               corr_on;
    bit                 steady = 1'b0;
    int                 mismatches = 0;
    int                 groups_taken = 0;
    int                 rows_checked = 0;
    int                 tiles_corr = 0;
    int                 tiles_raw = 0;
    int                 idle_cycles = 0;

    int8_gemm_tile_mac_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // fold one accepted k group into the tile; emit the four rows on the last group
    task automatic fold_group(input logic [IN_W-1:0] beat, input logic last);
        logic [31:0] bw;
        logic [31:0] bs;
        logic [31:0] dot;
        t_tile_row   row;
        begin
            for (int c = 0; c < 8; c++) begin
                bw = beat[4*32 + 32*c +: 32];
                for (int p = 0; p < 4; p++) begin
                    col_sum[c] += {{24{bw[8*p+7]}}, bw[8*p +: 8]};
                end
                for (int r = 0; r < 4; r++) begin
                    dot = '0;
                    for (int p = 0; p < 4; p++) begin
                        bs  = {{24{bw[8*p+7]}}, bw[8*p +: 8]};
                        dot += {24'd0, beat[32*r + 8*p +: 8]} * bs;
                    end
                    tile_acc[r][c] += dot;
                end
            end
            if (last) begin
                for (int r = 0; r < 4; r++) begin
                    row.row_index = r[1:0];
                    for (int c = 0; c < 8; c++) begin
                        row.sum_col[c] = tile_acc[r][c] - (corr_on ? col_sum[c] << 7 : 32'd0);
                    end
                    row.last_row = (r == 3);
                    rows_due.push_back(row);
                end
                if (corr_on) tiles_corr++;
                else tiles_raw++;
                for (int c = 0; c < 8; c++) begin
                    col_sum[c] = '0;
                    for (int r = 0; r < 4; r++) tile_acc[r][c] = '0;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %08h want %08h", $realtime, what, got, want);
        mismatches++;
    endtask

    // driver: next beat whenever the bus is free, gaps at random unless steady
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_axis_tdata  <= {pending[0].b_pair, pending[0].a_row};
                s_axis_tlast  <= pending[0].last_chunk;
                s_axis_tvalid <= 1'b1;
                void'(pending.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // monitor: predictor update on input beats, row check on output beats
    always @(posedge i_clk) begin
        t_tile_row want;
        if (!i_rst_n) begin
            corr_on = CORR_ON;
            for (int c = 0; c < 8; c++) begin
                col_sum[c] = '0;
                for (int r = 0; r < 4; r++) tile_acc[r][c] = '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) corr_on = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                fold_group(s_axis_tdata, s_axis_tlast);
                groups_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (rows_due.size() == 0) begin
                    report_mismatch("row beat with nothing pending, row_index",
                                    32'(m_axis_tuser), 32'd0);
                end else begin
                    want = rows_due.pop_front();
                    rows_checked++;
                    if (m_axis_tuser !== want.row_index)
                        report_mismatch("row_index", 32'(m_axis_tuser), 32'(want.row_index));
                    for (int c = 0; c < 8; c++) begin
                        if (m_axis_tdata[32*c +: 32] !== want.sum_col[c])
                            report_mismatch($sformatf("row %0d sum_col%0d", want.row_index, c),
                                            m_axis_tdata[32*c +: 32], want.sum_col[c]);
                    end
                    if (m_axis_tlast !== want.last_row)
                        report_mismatch("last_row", 32'(m_axis_tlast), 32'(want.last_row));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    endfunction

    function automatic t_k_group fill_group(input logic [31:0] a, input logic [31:0] b,
                                            input logic last);
        t_k_group g;
        for (int i = 0; i < 4; i++) begin
            g.a_row[i]  = a;
            g.b_pair[i] = {b, b};
        end
        g.last_chunk = last;
        return g;
    endfunction

    function automatic t_k_group rand_group(input logic last);
        t_k_group g;
        for (int i = 0; i < 4; i++) begin
            g.a_row[i]  = pick_word();
            g.b_pair[i] = {pick_word(), pick_word()};
        end
        g.last_chunk = last;
        return g;
    endfunction

    task automatic queue_directed();
        pending.push_back(fill_group(32'hFFFF_FFFF, 32'h7F7F_7F7F, 1'b1));
        pending.push_back(fill_group(32'hFFFF_FFFF, 32'h8080_8080, 1'b1));
        pending.push_back(fill_group(32'h0000_0000, 32'h8080_8080, 1'b1));
        pending.push_back(fill_group(32'h8080_8080, 32'h017F_80FF, 1'b1));
        pending.push_back(fill_group(32'hFFFF_FFFF, 32'h0000_0000, 1'b1));
        // long tile at the most negative dot product, accumulate-only beats first
        for (int i = 0; i < 6; i++)
            pending.push_back(fill_group(32'hFFFF_FFFF, 32'h8080_8080, i == 5));
        for (int i = 0; i < 4; i++) pending.push_back(rand_group(i == 3));
        pending.push_back(rand_group(1'b1));
    endtask

    task automatic queue_random(input int n_groups);
        int queued;
        int len;
        queued = 0;
        while (queued < n_groups) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) pending.push_back(rand_group(i == len - 1));
            queued += len;
        end
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending.size() != 0 || s_axis_tvalid || rows_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_correction(input logic on);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= on;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_directed();
        drain();
        set_correction(CORR_OFF);
        queue_directed();
        drain();
        set_correction(CORR_ON);
        queue_random(60);
        drain();
        set_correction(CORR_OFF);
        queue_random(50);
        drain();
        steady = 1'b1;          // no gaps on either side for this stretch
        queue_random(50);
        drain();
        steady = 1'b0;
        set_correction(CORR_ON);
        queue_random(55);
        drain();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d k groups and %0d tile rows checked", groups_taken,
                 rows_checked);
        $display("Tiles with offset correction: %0d, raw: %0d, mismatches: %0d",
                 tiles_corr, tiles_raw, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
